@@ hdl/tam_pkg.sv @@
`default_nettype none
package tam_pkg;

  localparam int NODE_W = 6;
  localparam int DRAW_W = 16;
  localparam int TEN_W  = 6;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [TEN_W-1:0] TEN_MAX       = 6'd63;
  localparam logic [TEN_W-1:0] MIN_TEN_RESET = 6'd20;
  localparam logic [TEN_W-1:0] MAX_TEN_RESET = 6'd40;

  localparam logic [1:0] ACT_QUERY = 2'd0;
  localparam logic [1:0] ACT_MARK  = 2'd1;
  localparam logic [1:0] ACT_AGE   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // word index of a register, taken from paddr[2]
  localparam logic REG_MIN_TENURE = 1'b0;
  localparam logic REG_MAX_TENURE = 1'b1;

endpackage
`default_nettype wire

@@ hdl/tam_ram.sv @@
`default_nettype none
module tam_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/tabu_arc_memory.sv @@
// query: S_RD reads the entry, S_QDATA gives the result; mark: a 16-step remainder unit
// (S_DIV), then S_RD and S_MARK; age and clear: a one-entry-a-cycle sweep over the tenure
// memory, then S_RD and S_QDATA; one item in flight, busy high until its result is out
// reset: a clearing pass writes zero to all NODES*NODES entries, busy high for that long
// results are one-cycle strobes on done; the receiver cannot stall them
`default_nettype none
module tabu_arc_memory #(
  parameter int NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action,
  input  wire logic [tam_pkg::NODE_W-1:0]    from_node,
  input  wire logic [tam_pkg::NODE_W-1:0]    to_node,
  input  wire logic [tam_pkg::DRAW_W-1:0]    random_draw,
  output logic                               done,
  output logic                               arc_tabu,
  output logic      [tam_pkg::TEN_W-1:0]     remaining_tenure,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tam_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tam_pkg::DATA_W-1:0]    pwdata,
  output logic      [tam_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int DEPTH  = NODES * NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SWP_W  = ADDR_W + 1;
  localparam int STEP_W = $clog2(tam_pkg::DRAW_W);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_RD, S_QDATA, S_MARK, S_AGE
  } state_t;

  state_t                      state;
  logic [1:0]                  act;
  logic [ADDR_W-1:0]           idx;
  logic                        ok;
  logic [tam_pkg::DRAW_W-1:0]  draw;
  logic [tam_pkg::TEN_W-1:0]   rem;
  logic [STEP_W-1:0]           step;
  logic [SWP_W-1:0]            sweep;
  logic                        clr_init;
  logic [tam_pkg::TEN_W-1:0]   min_tenure;
  logic [tam_pkg::TEN_W-1:0]   max_tenure;

  logic                        in_ok;
  logic [ADDR_W-1:0]           in_idx;
  logic [31:0]                 idx_full;
  logic [tam_pkg::TEN_W-1:0]   span;
  logic [tam_pkg::TEN_W:0]     rem_sh;
  logic [tam_pkg::TEN_W-1:0]   tenure;
  logic [tam_pkg::TEN_W:0]     mark_sum;
  logic [tam_pkg::TEN_W-1:0]   mark_val;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [tam_pkg::TEN_W-1:0]   wr_data;
  logic [ADDR_W-1:0]           rd_addr;
  logic [tam_pkg::TEN_W-1:0]   rd_data;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      min_tenure <= tam_pkg::MIN_TEN_RESET;
      max_tenure <= tam_pkg::MAX_TEN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        tam_pkg::REG_MIN_TENURE: min_tenure <= pwdata[tam_pkg::TEN_W-1:0];
        tam_pkg::REG_MAX_TENURE: max_tenure <= pwdata[tam_pkg::TEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tam_pkg::REG_MIN_TENURE: prdata = tam_pkg::DATA_W'(min_tenure);
      tam_pkg::REG_MAX_TENURE: prdata = tam_pkg::DATA_W'(max_tenure);
      default:                 prdata = '0;
    endcase
  end

  // arc address, out-of-range arcs map to entry 0 and report zero
  assign idx_full = 32'(from_node) * 32'(NODES) + 32'(to_node);
  assign in_ok    = (32'(from_node) < 32'(NODES)) && (32'(to_node) < 32'(NODES));
  assign in_idx   = in_ok ? idx_full[ADDR_W-1:0] : '0;

  // draw mod (max - min), one quotient bit per cycle
  assign span   = max_tenure - min_tenure;
  assign rem_sh = {rem, draw[tam_pkg::DRAW_W-1]};

  assign tenure   = (max_tenure > min_tenure) ? rem + min_tenure : min_tenure;
  assign mark_sum = {1'b0, tenure} + {{tam_pkg::TEN_W{1'b0}}, (rd_data != '0)};
  assign mark_val = mark_sum[tam_pkg::TEN_W] ? tam_pkg::TEN_MAX
                                             : mark_sum[tam_pkg::TEN_W-1:0];

  // memory port control
  always_comb begin
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = mark_val;
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = sweep[ADDR_W-1:0];
        wr_data = '0;
      end
      S_AGE: begin
        // read entry sweep, write back entry sweep-1 in the cycle after its read
        rd_addr = sweep[ADDR_W-1:0];
        wr_en   = (sweep != '0);
        wr_addr = ADDR_W'(sweep - SWP_W'(1));
        wr_data = (rd_data != '0) ? rd_data - tam_pkg::TEN_W'(1) : '0;
      end
      S_MARK: begin
        wr_en = ok;
      end
      default: ;
    endcase
  end

  tam_ram #(
    .WIDTH (tam_pkg::TEN_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      sweep    <= '0;
      clr_init <= 1'b1;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          sweep <= sweep + SWP_W'(1);
          if (sweep == SWP_W'(DEPTH - 1)) begin
            sweep    <= '0;
            clr_init <= 1'b0;
            state    <= clr_init ? S_IDLE : S_RD;
          end
        end
        S_IDLE: begin
          if (start) begin
            act   <= action;
            idx   <= in_idx;
            ok    <= in_ok;
            draw  <= random_draw;
            rem   <= '0;
            step  <= '0;
            sweep <= '0;
            case (action)
              tam_pkg::ACT_QUERY: state <= S_RD;
              tam_pkg::ACT_MARK:  state <= S_DIV;
              tam_pkg::ACT_AGE:   state <= S_AGE;
              tam_pkg::ACT_CLEAR: state <= S_CLR;
              default:            state <= S_RD;
            endcase
          end
        end
        S_DIV: begin
          draw <= draw << 1;
          step <= step + STEP_W'(1);
          if (rem_sh >= {1'b0, span}) begin
            rem <= tam_pkg::TEN_W'(rem_sh - {1'b0, span});
          end else begin
            rem <= rem_sh[tam_pkg::TEN_W-1:0];
          end
          if (step == STEP_W'(tam_pkg::DRAW_W - 1)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (act == tam_pkg::ACT_MARK) ? S_MARK : S_QDATA;
        end
        S_QDATA: begin
          done             <= 1'b1;
          remaining_tenure <= ok ? rd_data : '0;
          arc_tabu         <= ok && (rd_data != '0);
          state            <= S_IDLE;
        end
        S_MARK: begin
          done             <= 1'b1;
          remaining_tenure <= ok ? mark_val : '0;
          arc_tabu         <= ok && (mark_val != '0);
          state            <= S_IDLE;
        end
        S_AGE: begin
          sweep <= sweep + SWP_W'(1);
          if (sweep == SWP_W'(DEPTH)) begin
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result out while an action is still running");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("tenure memory written while idle");

  a_reset_clears: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("no clearing pass after reset");

  a_tabu_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (arc_tabu == (remaining_tenure != '0)))
    else $error("tabu flag disagrees with the tenure word");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
  import tam_pkg::*;

  localparam int NODES = 64;
  localparam int ARCS = NODES * NODES;
  // a sweep after reset or on age/clear keeps the block busy while it walks all ARCS entries
  localparam int IDLE_LIMIT = 5 * ARCS;

  typedef struct packed {
    logic               tabu;
    logic [TEN_W-1:0]   tenure;
  } arc_report_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = ACT_QUERY;
  logic [NODE_W-1:0] from_node = '0;
  logic [NODE_W-1:0] to_node = '0;
  logic [DRAW_W-1:0] random_draw = '0;
  logic done;
  logic arc_tabu;
  logic [TEN_W-1:0] remaining_tenure;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // predictor state
  logic [TEN_W-1:0] tenure_mem [ARCS];
  logic [TEN_W-1:0] min_ten_q = MIN_TEN_RESET;
  logic [TEN_W-1:0] max_ten_q = MAX_TEN_RESET;
  arc_report_t expected_arc_q[$];

  int errors = 0;
  int words_checked = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int reg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [NODE_W-1:0] last_from = '0;
  logic [NODE_W-1:0] last_to = '0;

  tabu_arc_memory #(.NODES(NODES)) i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .from_node        (from_node),
    .to_node          (to_node),
    .random_draw      (random_draw),
    .done             (done),
    .arc_tabu         (arc_tabu),
    .remaining_tenure (remaining_tenure),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ARCS; i++) tenure_mem[i] = '0;
  end

  function automatic arc_report_t apply_arc_cmd(logic [1:0] act, logic [NODE_W-1:0] fn,
                                               logic [NODE_W-1:0] tn, logic [DRAW_W-1:0] drw);
    arc_report_t r;
    bit arc_ok;
    int slot;
    int t;
    arc_ok = (int'(fn) < NODES) && (int'(tn) < NODES);
    slot = arc_ok ? int'(fn) * NODES + int'(tn) : 0;
    case (act)
      ACT_MARK: begin
        if (arc_ok) begin
          if (max_ten_q > min_ten_q)
            t = int'(drw) % (int'(max_ten_q) - int'(min_ten_q)) + int'(min_ten_q);
          else
            t = int'(min_ten_q);
          if (tenure_mem[slot] != 0) t = t + 1;
          if (t > int'(TEN_MAX)) t = int'(TEN_MAX);
          tenure_mem[slot] = t[TEN_W-1:0];
        end
      end
      ACT_AGE: begin
        for (int i = 0; i < ARCS; i++)
          if (tenure_mem[i] != 0) tenure_mem[i] = tenure_mem[i] - 1'b1;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < ARCS; i++) tenure_mem[i] = '0;
      end
      default: ;
    endcase
    r.tenure = arc_ok ? tenure_mem[slot] : '0;
    r.tabu = (r.tenure != 0);
    return r;
  endfunction

  // result checker: done is a one-cycle strobe, sampled at the edge that ends it
  always @(posedge clk) begin
    arc_report_t exp_r;
    if (!rst && done) begin
      if (expected_arc_q.size() == 0) begin
        $display("%0t: unexpected word: actual tabu=%0b tenure=%0d", $time, arc_tabu,
                 remaining_tenure);
        errors++;
      end else begin
        exp_r = expected_arc_q.pop_front();
        words_checked++;
        if (arc_tabu !== exp_r.tabu) begin
          $display("%0t: arc_tabu mismatch: expected %0b actual %0b", $time, exp_r.tabu,
                   arc_tabu);
          errors++;
        end
        if (remaining_tenure !== exp_r.tenure) begin
          $display("%0t: remaining_tenure mismatch: expected %0d actual %0d", $time,
                   exp_r.tenure, remaining_tenure);
          errors++;
        end
      end
    end
  end

  // watchdog on forward progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_arc_cmd(input logic [1:0] act, input logic [NODE_W-1:0] fn,
                              input logic [NODE_W-1:0] tn, input logic [DRAW_W-1:0] drw);
    arc_report_t exp_r;
    start <= 1'b1;
    action <= act;
    from_node <= fn;
    to_node <= tn;
    random_draw <= drw;
    do @(posedge clk); while (busy);
    exp_r = apply_arc_cmd(act, fn, tn, drw);
    expected_arc_q = {expected_arc_q, exp_r};
    cmd_count[act]++;
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_arc_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // return to idle between transfers
    @(posedge clk);
  endtask

  // write a tenure register with junk above bit 5, then read it back
  task automatic write_tenure_reg(input logic idx, input logic [TEN_W-1:0] val);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] wd;
    drain();
    wd = ($urandom() & ~32'h3F) | DATA_W'(val);
    apb_xfer(1'b1, {idx, 2'b00}, wd, rd);
    if (idx == REG_MIN_TENURE) min_ten_q = val;
    else max_ten_q = val;
    reg_writes++;
    apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
    if (rd !== DATA_W'(val)) begin
      $display("%0t: readback of reg %0d: expected %0d actual %0d", $time, idx, val, rd);
      errors++;
    end
  endtask

  task automatic set_tenure(input logic [TEN_W-1:0] lo, input logic [TEN_W-1:0] hi);
    write_tenure_reg(REG_MIN_TENURE, lo);
    write_tenure_reg(REG_MAX_TENURE, hi);
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return NODE_W'($urandom_range(0, 3));
    if (roll < 75) return NODE_W'($urandom_range(60, 63));
    return NODE_W'($urandom_range(0, NODES - 1));
  endfunction

  task automatic test_reset_state;
    send_arc_cmd(ACT_QUERY, 6'd0, 6'd0, 16'h0000);
    send_arc_cmd(ACT_QUERY, 6'd63, 6'd63, 16'hFFFF);
  endtask

  task automatic test_mark_query;
    send_arc_cmd(ACT_MARK, 6'd63, 6'd0, 16'h0000);
    send_arc_cmd(ACT_MARK, 6'd0, 6'd63, 16'hFFFF);
    hold_off(3);
    // already tabu, so tenure+1
    send_arc_cmd(ACT_MARK, 6'd0, 6'd63, 16'h8001);
    send_arc_cmd(ACT_QUERY, 6'd63, 6'd0, 16'h1234);
  endtask

  task automatic test_age_clear;
    send_arc_cmd(ACT_AGE, 6'd63, 6'd0, 16'h0000);
    send_arc_cmd(ACT_AGE, 6'd5, 6'd5, 16'hFFFF);
    send_arc_cmd(ACT_CLEAR, 6'd0, 6'd63, 16'h0000);
    send_arc_cmd(ACT_QUERY, 6'd63, 6'd0, 16'h0000);
  endtask

  task automatic test_tenure_extremes;
    set_tenure(6'd1, 6'd63);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd20, 16'hFFFF);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd21, 16'd61);
    set_tenure(6'd62, 6'd63);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd22, 16'h5A5A);
    // max not above min: tenure is min
    set_tenure(6'd62, 6'd2);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd22, 16'hA5A5);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd23, 16'h0F0F);
    // tenure+1 saturates at the counter max
    set_tenure(6'd63, 6'd0);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd22, 16'h0000);
    // zero tenure leaves a fresh arc non-tabu
    set_tenure(6'd0, 6'd0);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd24, 16'h7777);
    send_arc_cmd(ACT_QUERY, 6'd10, 6'd24, 16'h0000);
    send_arc_cmd(ACT_MARK, 6'd10, 6'd22, 16'h3333);
  endtask

  task automatic random_phase(input logic [TEN_W-1:0] lo, input logic [TEN_W-1:0] hi,
                              input int n_items, input bit with_gaps);
    int roll;
    logic [1:0] act;
    logic [NODE_W-1:0] fn;
    logic [NODE_W-1:0] tn;
    set_tenure(lo, hi);
    burst_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (with_gaps && burst_left == 0) begin
        hold_off($urandom_range(1, 6));
        burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0) burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 42) act = ACT_MARK;
      else if (roll < 82) act = ACT_QUERY;
      else if (roll < 96) act = ACT_AGE;
      else act = ACT_CLEAR;
      // revisit the last marked arc half the time (a third for marks) so marks and queries meet
      if (act != ACT_MARK && $urandom_range(0, 1)) begin
        fn = last_from;
        tn = last_to;
      end else begin
        fn = pick_node();
        tn = pick_node();
      end
      if (act == ACT_MARK && $urandom_range(0, 2) != 0) begin
        fn = last_from;
        tn = last_to;
        if ($urandom_range(0, 1)) begin
          fn = pick_node();
          tn = pick_node();
        end
      end
      send_arc_cmd(act, fn, tn, DRAW_W'($urandom()));
      if (act == ACT_MARK) begin
        last_from = fn;
        last_to = tn;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_mark_query();
    test_age_clear();
    test_tenure_extremes();
    random_phase(6'd1, 6'd63, 30, 1'b1);
    random_phase(6'd62, 6'd63, 30, 1'b0);
    random_phase(6'($urandom_range(1, 62)), 6'($urandom_range(2, 63)), 30, 1'b1);
    random_phase(6'd20, 6'd40, 30, 1'b1);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d queries, %0d marks, %0d ages, %0d clears, %0d register writes",
             cmd_count[ACT_QUERY], cmd_count[ACT_MARK], cmd_count[ACT_AGE],
             cmd_count[ACT_CLEAR], reg_writes);
    $display("%0d result words checked, %0d errors", words_checked, errors);
    if (errors == 0 && expected_arc_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tam_pkg.sv
hdl/tam_ram.sv
hdl/tabu_arc_memory.sv
tb/testbench.sv
